/* hdl/pid_with_conditional_integration_assert.svh */
`ifndef PID_WITH_CONDITIONAL_INTEGRATION_ASSERT_SVH
`define PID_WITH_CONDITIONAL_INTEGRATION_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define PIDCI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidci port check failed");

// property that must hold from the cycle after its trigger
`define PIDCI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidci port check failed");

`endif

/* hdl/pidci_pkg.sv */
package pidci_pkg;

    localparam int TIME_W      = 32;
    localparam int MUL_DIGIT_W = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_D         = 3'd1,
        CFG_GAIN_I         = 3'd2,
        CFG_OUTPUT_FLOOR   = 3'd3,
        CFG_OUTPUT_CEILING = 3'd4,
        CFG_SETPOINT       = 3'd5,
        CFG_START_TIME     = 3'd6
    } pidci_cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MUL_P,
        ST_MUL_D,
        ST_MUL_I,
        ST_MUL_E,
        ST_CLAMP,
        ST_WRITE
    } pidci_state_t;

    // operand pair fed to the shared multiplier
    typedef enum logic [1:0] {
        MS_P,
        MS_D,
        MS_I,
        MS_E
    } pidci_mul_sel_t;

    typedef struct packed {
        logic           load;
        logic           prime;
        logic           div_start;
        logic           acc_clear;
        logic           mul_start;
        pidci_mul_sel_t mul_sel;
        logic           acc_add;
        logic           eprod_load;
        logic           clamp;
        logic           commit;
    } pidci_cmd_t;

    typedef struct packed {
        logic stale;
        logic primed;
        logic div_done;
        logic mul_done;
        logic out_free;
    } pidci_status_t;

endpackage

/* hdl/pidci_if.sv */
interface pidci_in_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                              valid;
    logic                              ready;
    logic signed [VALUE_WIDTH-1:0]     measurement;
    logic [pidci_pkg::TIME_W-1:0]      timestamp;

    modport source (output valid, output measurement, output timestamp, input ready);
    modport sink (input valid, input measurement, input timestamp, output ready);
endinterface

interface pidci_out_if #(
    parameter int VALUE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] drive;
    logic                          saturated;

    modport source (output valid, output drive, output saturated, input ready);
    modport sink (input valid, input drive, input saturated, output ready);
endinterface

/* hdl/pidci_div.sv */
module pidci_div #(
    parameter int N_W = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [N_W-1:0]               num_mag,
    input  logic [pidci_pkg::TIME_W-1:0] den,
    output logic                         done,
    output logic [N_W-1:0]               quot
);
    localparam int TW    = pidci_pkg::TIME_W;
    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   q_reg;
    logic [TW-1:0]    rem_reg;
    logic [TW-1:0]    den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [TW:0]      trial;
    logic [TW:0]      trial_diff;
    logic             fit;
    logic [TW-1:0]    rem_next;

    // remainder stays below the divisor, so the top bit of the difference is the borrow
    assign trial      = {rem_reg, q_reg[N_W-1]};
    assign trial_diff = trial - {1'b0, den_reg};
    assign fit        = !trial_diff[TW];
    assign rem_next   = fit ? trial_diff[TW-1:0] : trial[TW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num_mag;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[N_W-2:0], fit};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* hdl/pidci_mul.sv */
module pidci_mul #(
    parameter int A_W = 48,
    parameter int B_W = 32,
    localparam int N_DIG = (B_W + pidci_pkg::MUL_DIGIT_W - 1) / pidci_pkg::MUL_DIGIT_W,
    localparam int P_W   = A_W + N_DIG * pidci_pkg::MUL_DIGIT_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [A_W-1:0]      a_mag,
    input  logic [B_W-1:0]      b_mag,
    input  logic                neg,
    output logic                done,
    output logic signed [P_W:0] product
);
    localparam int DW    = pidci_pkg::MUL_DIGIT_W;
    localparam int BP_W  = N_DIG * DW;
    localparam int CNT_W = $clog2(N_DIG + 1);

    logic [A_W-1:0]      a_reg;
    logic [BP_W-1:0]     b_reg;
    logic                neg_reg;
    logic [P_W-1:0]      acc_reg;
    logic [P_W-1:0]      acc_next;
    logic [A_W+DW-1:0]   partial;
    logic [P_W:0]        mag_ext;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic signed [P_W:0] product_reg;

    // most significant digit of b first, accumulator shifts one digit per step
    assign partial  = a_reg * b_reg[BP_W-1 -: DW];
    assign acc_next = {acc_reg[P_W-DW-1:0], DW'(0)} + P_W'(partial);
    assign mag_ext  = {1'b0, acc_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(N_DIG);
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_mag;
            b_reg   <= BP_W'(b_mag);
            neg_reg <= neg;
            acc_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            acc_reg <= acc_next;
            b_reg   <= b_reg << DW;
        end
        else if (busy_reg)
        begin
            // sign step
            product_reg <= neg_reg ? -mag_ext : mag_ext;
        end
    end

    assign done    = done_reg;
    assign product = product_reg;

endmodule

/* hdl/pidci_dp.sv */
module pidci_dp #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS = 16,
    parameter int INTEGRAL_WIDTH = 48,
    localparam int CFG_W = (VALUE_WIDTH > pidci_pkg::TIME_W) ? VALUE_WIDTH : pidci_pkg::TIME_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pidci_pkg::pidci_cmd_t             cmd,
    output pidci_pkg::pidci_status_t          status,
    input  logic                              cfg_write_en,
    input  logic [pidci_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data,
    input  logic signed [VALUE_WIDTH-1:0]     measurement,
    input  logic [pidci_pkg::TIME_W-1:0]      timestamp,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic signed [VALUE_WIDTH-1:0]     drive,
    output logic                              saturated
);
    localparam int VW     = VALUE_WIDTH;
    localparam int IW     = INTEGRAL_WIDTH;
    localparam int TW     = pidci_pkg::TIME_W;
    localparam int AW     = (VW > IW) ? VW : IW;
    localparam int BW     = CFG_W;
    localparam int DW     = pidci_pkg::MUL_DIGIT_W;
    localparam int BPW    = ((BW + DW - 1) / DW) * DW;
    localparam int SPW    = AW + BPW + 1;
    localparam int TERM_W = SPW - FRAC_BITS;
    localparam int SW     = TERM_W + 2;
    localparam int ISW    = SPW + 1;

    // configuration
    logic signed [VW-1:0] gain_p_reg;
    logic signed [VW-1:0] gain_d_reg;
    logic signed [VW-1:0] gain_i_reg;
    logic signed [VW-1:0] floor_reg;
    logic signed [VW-1:0] ceil_reg;
    logic signed [VW-1:0] setpoint_reg;

    // running state
    logic [TW-1:0]        prev_time_reg;
    logic signed [VW-1:0] prev_err_reg;
    logic signed [IW-1:0] integral_reg;
    logic signed [IW-1:0] integral_next;
    logic                 primed_reg;

    // per-sample work registers
    logic signed [VW-1:0]  err_reg;
    logic signed [VW-1:0]  err_next;
    logic [TW-1:0]         ts_reg;
    logic [TW-1:0]         dt_reg;
    logic [TW-1:0]         dt_next;
    logic                  rate_neg_reg;
    logic signed [SW-1:0]  acc_reg;
    logic signed [SW-1:0]  acc_next;
    logic signed [SPW-1:0] eprod_reg;
    logic signed [VW-1:0]  drive_reg;
    logic signed [VW-1:0]  drive_next;

    // result register
    logic                 out_valid_reg;
    logic signed [VW-1:0] out_drive_reg;
    logic                 out_sat_reg;

    logic signed [VW:0]    err_diff;
    logic signed [VW:0]    rate_diff;
    logic [VW:0]           rate_diff_abs;
    logic [VW-1:0]         num_mag;
    logic [VW-1:0]         quot;
    logic                  div_done;
    logic [VW-1:0]         err_mag;
    logic [VW-1:0]         gp_mag;
    logic [VW-1:0]         gd_mag;
    logic [VW-1:0]         gi_mag;
    logic [IW-1:0]         int_mag;
    logic [AW-1:0]         mul_a;
    logic [BW-1:0]         mul_b;
    logic                  mul_neg;
    logic                  mul_done;
    logic signed [SPW-1:0] product;
    logic signed [TERM_W-1:0] term;
    logic signed [SW-1:0]  ceil_ext;
    logic signed [SW-1:0]  floor_ext;
    logic                  sat;
    logic signed [ISW-1:0] int_sum;
    logic [ISW-IW:0]       int_top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= '0;
            gain_d_reg   <= '0;
            gain_i_reg   <= '0;
            floor_reg    <= {1'b1, {(VW-1){1'b0}}};
            ceil_reg     <= {1'b0, {(VW-1){1'b1}}};
            setpoint_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (pidci_pkg::pidci_cfg_index_t'(cfg_index))
                pidci_pkg::CFG_GAIN_P:         gain_p_reg   <= cfg_data[VW-1:0];
                pidci_pkg::CFG_GAIN_D:         gain_d_reg   <= cfg_data[VW-1:0];
                pidci_pkg::CFG_GAIN_I:         gain_i_reg   <= cfg_data[VW-1:0];
                pidci_pkg::CFG_OUTPUT_FLOOR:   floor_reg    <= cfg_data[VW-1:0];
                pidci_pkg::CFG_OUTPUT_CEILING: ceil_reg     <= cfg_data[VW-1:0];
                pidci_pkg::CFG_SETPOINT:       setpoint_reg <= cfg_data[VW-1:0];
                default:
                begin
                    // start time only matters through the previous time below
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            prev_err_reg  <= '0;
            integral_reg  <= '0;
            primed_reg    <= 1'b0;
        end
        else if (cmd.prime)
        begin
            prev_time_reg <= ts_reg;
            prev_err_reg  <= err_reg;
            primed_reg    <= 1'b1;
        end
        else if (cmd.commit)
        begin
            prev_time_reg <= ts_reg;
            prev_err_reg  <= err_reg;
            if (!sat)
            begin
                integral_reg <= integral_next;
            end
        end
        else if (cfg_write_en && !primed_reg &&
                 (pidci_pkg::pidci_cfg_index_t'(cfg_index) == pidci_pkg::CFG_START_TIME))
        begin
            prev_time_reg <= cfg_data[TW-1:0];
        end
    end

    // error, saturated to the value width
    assign err_diff = {setpoint_reg[VW-1], setpoint_reg} - {measurement[VW-1], measurement};

    always_comb
    begin
        priority if (err_diff[VW] && !err_diff[VW-1])
        begin
            err_next = {1'b1, {(VW-1){1'b0}}};
        end
        else if (!err_diff[VW] && err_diff[VW-1])
        begin
            err_next = {1'b0, {(VW-1){1'b1}}};
        end
        else
        begin
            err_next = err_diff[VW-1:0];
        end
    end

    assign dt_next       = ts_reg - prev_time_reg;
    assign rate_diff     = {err_reg[VW-1], err_reg} - {prev_err_reg[VW-1], prev_err_reg};
    assign rate_diff_abs = rate_diff[VW] ? -rate_diff : rate_diff;
    assign num_mag       = rate_diff_abs[VW-1:0];

    pidci_div #(
        .N_W (VW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.div_start),
        .num_mag (num_mag),
        .den     (dt_next),
        .done    (div_done),
        .quot    (quot)
    );

    assign err_mag = err_reg[VW-1] ? -err_reg : err_reg;
    assign gp_mag  = gain_p_reg[VW-1] ? -gain_p_reg : gain_p_reg;
    assign gd_mag  = gain_d_reg[VW-1] ? -gain_d_reg : gain_d_reg;
    assign gi_mag  = gain_i_reg[VW-1] ? -gain_i_reg : gain_i_reg;
    assign int_mag = integral_reg[IW-1] ? -integral_reg : integral_reg;

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        unique case (cmd.mul_sel)
            pidci_pkg::MS_P:
            begin
                mul_a   = AW'(err_mag);
                mul_b   = BW'(gp_mag);
                mul_neg = err_reg[VW-1] ^ gain_p_reg[VW-1];
            end
            pidci_pkg::MS_D:
            begin
                mul_a   = AW'(quot);
                mul_b   = BW'(gd_mag);
                mul_neg = rate_neg_reg ^ gain_d_reg[VW-1];
            end
            pidci_pkg::MS_I:
            begin
                mul_a   = AW'(int_mag);
                mul_b   = BW'(gi_mag);
                mul_neg = integral_reg[IW-1] ^ gain_i_reg[VW-1];
            end
            pidci_pkg::MS_E:
            begin
                mul_a   = AW'(err_mag);
                mul_b   = BW'(dt_reg);
                mul_neg = err_reg[VW-1];
            end
        endcase
    end

    pidci_mul #(
        .A_W (AW),
        .B_W (BW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a_mag   (mul_a),
        .b_mag   (mul_b),
        .neg     (mul_neg),
        .done    (mul_done),
        .product (product)
    );

    // arithmetic shift drops the fraction, rounding toward minus infinity
    assign term     = product[SPW-1:FRAC_BITS];
    assign acc_next = acc_reg + SW'(term);

    assign ceil_ext  = SW'(ceil_reg);
    assign floor_ext = SW'(floor_reg);

    // limit to the ceiling first, then raise to the floor
    always_comb
    begin
        priority if (acc_reg > ceil_ext)
        begin
            drive_next = (ceil_reg < floor_reg) ? floor_reg : ceil_reg;
        end
        else if (acc_reg < floor_ext)
        begin
            drive_next = floor_reg;
        end
        else
        begin
            drive_next = acc_reg[VW-1:0];
        end
    end

    assign sat = (drive_reg >= ceil_reg) || (drive_reg <= floor_reg);

    assign int_sum = ISW'(integral_reg) + ISW'(eprod_reg);
    assign int_top = int_sum[ISW-1:IW-1];

    always_comb
    begin
        priority if (int_sum[ISW-1] && !(&int_top))
        begin
            integral_next = {1'b1, {(IW-1){1'b0}}};
        end
        else if (!int_sum[ISW-1] && (|int_top))
        begin
            integral_next = {1'b0, {(IW-1){1'b1}}};
        end
        else
        begin
            integral_next = int_sum[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg <= err_next;
            ts_reg  <= timestamp;
        end
        if (cmd.div_start)
        begin
            dt_reg       <= dt_next;
            rate_neg_reg <= rate_diff[VW];
        end
        if (cmd.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.eprod_load)
        begin
            eprod_reg <= product;
        end
        if (cmd.clamp)
        begin
            drive_reg <= drive_next;
        end
        if (cmd.commit)
        begin
            out_drive_reg <= drive_reg;
            out_sat_reg   <= sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.stale    = (ts_reg <= prev_time_reg);
    assign status.primed   = primed_reg;
    assign status.div_done = div_done;
    assign status.mul_done = mul_done;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign drive     = out_drive_reg;
    assign saturated = out_sat_reg;

endmodule

/* hdl/pidci_ctrl.sv */
module pidci_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  pidci_pkg::pidci_status_t status,
    output logic                     in_ready,
    output pidci_pkg::pidci_cmd_t    cmd
);
    pidci_pkg::pidci_state_t state_reg;
    pidci_pkg::pidci_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidci_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidci_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = pidci_pkg::ST_CHECK;
                end
            end
            pidci_pkg::ST_CHECK:
            begin
                // stale and priming samples end here
                if (status.stale || !status.primed)
                begin
                    state_next = pidci_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = pidci_pkg::ST_DIV;
                end
            end
            pidci_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = pidci_pkg::ST_MUL_P;
                end
            end
            pidci_pkg::ST_MUL_P:
            begin
                if (status.mul_done)
                begin
                    state_next = pidci_pkg::ST_MUL_D;
                end
            end
            pidci_pkg::ST_MUL_D:
            begin
                if (status.mul_done)
                begin
                    state_next = pidci_pkg::ST_MUL_I;
                end
            end
            pidci_pkg::ST_MUL_I:
            begin
                if (status.mul_done)
                begin
                    state_next = pidci_pkg::ST_MUL_E;
                end
            end
            pidci_pkg::ST_MUL_E:
            begin
                if (status.mul_done)
                begin
                    state_next = pidci_pkg::ST_CLAMP;
                end
            end
            pidci_pkg::ST_CLAMP:
            begin
                state_next = pidci_pkg::ST_WRITE;
            end
            pidci_pkg::ST_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = pidci_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidci_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = pidci_pkg::MS_P;
        in_ready    = 1'b0;
        unique case (state_reg)
            pidci_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            pidci_pkg::ST_CHECK:
            begin
                cmd.prime     = !status.stale && !status.primed;
                cmd.div_start = !status.stale && status.primed;
                cmd.acc_clear = !status.stale && status.primed;
            end
            pidci_pkg::ST_DIV:
            begin
                cmd.mul_start = status.div_done;
                cmd.mul_sel   = pidci_pkg::MS_P;
            end
            pidci_pkg::ST_MUL_P:
            begin
                cmd.acc_add   = status.mul_done;
                cmd.mul_start = status.mul_done;
                cmd.mul_sel   = pidci_pkg::MS_D;
            end
            pidci_pkg::ST_MUL_D:
            begin
                cmd.acc_add   = status.mul_done;
                cmd.mul_start = status.mul_done;
                cmd.mul_sel   = pidci_pkg::MS_I;
            end
            pidci_pkg::ST_MUL_I:
            begin
                // error times dt is formed anyway, used only when not saturated
                cmd.acc_add   = status.mul_done;
                cmd.mul_start = status.mul_done;
                cmd.mul_sel   = pidci_pkg::MS_E;
            end
            pidci_pkg::ST_MUL_E:
            begin
                cmd.eprod_load = status.mul_done;
            end
            pidci_pkg::ST_CLAMP:
            begin
                cmd.clamp = 1'b1;
            end
            pidci_pkg::ST_WRITE:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/pid_with_conditional_integration.sv */
// One axis of a PID regulator with clamping anti-windup, signed fixed point.
// in_ch carries measurement and timestamp, out_ch carries drive and the
// saturated flag; both use valid/ready and a transfer happens when both are high.
// Gains, limits, setpoint and start time are written through cfg_write_en,
// cfg_index and cfg_data; the user must write them while no sample is in
// flight, as the block itself does not enforce it. A stale sample
// (timestamp not later than the previous one) or the first non-stale
// sample after reset produces no result; the input is freed again after
// the check state. Every other sample is handled one at a time, in order:
// check, the remainder divider for the rate, four products on the shared
// 16-bit-digit multiplier, clamp and write.
// The result sits in an output register; the block keeps working on the
// next sample while it waits, and only the final write stalls while the
// receiver holds ready low.
// Reset clears the integral, previous error and previous time and returns
// the configuration to zero gains and full-range limits.
module pid_with_conditional_integration #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS = 16,
    parameter int INTEGRAL_WIDTH = 48,
    localparam int CFG_W = (VALUE_WIDTH > pidci_pkg::TIME_W) ? VALUE_WIDTH : pidci_pkg::TIME_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [pidci_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]                  cfg_data,
    pidci_in_if.sink                          in_ch,
    pidci_out_if.source                       out_ch
);
    pidci_pkg::pidci_cmd_t    cmd;
    pidci_pkg::pidci_status_t status;

    pidci_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .status   (status),
        .in_ready (in_ch.ready),
        .cmd      (cmd)
    );

    pidci_dp #(
        .VALUE_WIDTH    (VALUE_WIDTH),
        .FRAC_BITS      (FRAC_BITS),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .measurement  (in_ch.measurement),
        .timestamp    (in_ch.timestamp),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .drive        (out_ch.drive),
        .saturated    (out_ch.saturated)
    );

endmodule

/* hdl/pidci_checker.sv */
`include "pid_with_conditional_integration_assert.svh"

module pidci_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [VALUE_WIDTH-1:0] drive,
    input logic                          saturated
);
    // a stalled result holds
    `PIDCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(drive) && $stable(saturated))

    // one sample at a time: input closes after each transfer
    `PIDCI_ASSERT_NEXT(a_in_closes, in_valid && in_ready, !in_ready)

    // a new result only comes out of the final write, never while idle
    `PIDCI_ASSERT_NOW(a_out_from_write, $rose(out_valid), $past(!in_ready))

    // no new result can rise straight after an input transfer
    `PIDCI_ASSERT_NEXT(a_min_latency, in_valid && in_ready, !$rose(out_valid) ##1 !$rose(out_valid))

endmodule

bind pid_with_conditional_integration pidci_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_pidci_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .drive     (out_ch.drive),
    .saturated (out_ch.saturated)
);

/* tb/sv/tb_pid_with_conditional_integration.sv */
`timescale 1ns / 1ps

module tb_pid_with_conditional_integration;

    localparam int VW = 32;
    localparam int FRAC = 16;
    localparam int IW = 48;
    localparam int IDX_W = pidci_pkg::CFG_INDEX_W;
    localparam int PHASE_ITEMS = 250;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [31:0] STAMP_CAP = 32'hF000_0000;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
    localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

    typedef struct packed {
        logic signed [VW-1:0] measurement;
        logic [31:0]          timestamp;
    } sample_t;

    typedef struct packed {
        logic signed [VW-1:0] drive;
        logic                 saturated;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write_en;
    logic [IDX_W-1:0] cfg_index;
    logic [VW-1:0] cfg_data;

    pidci_in_if #(.VALUE_WIDTH(VW)) in_if ();
    pidci_out_if #(.VALUE_WIDTH(VW)) out_if ();

    pid_with_conditional_integration #(
        .VALUE_WIDTH(VW),
        .FRAC_BITS(FRAC),
        .INTEGRAL_WIDTH(IW)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_if),
        .out_ch(out_if)
    );

    always #5 clk = ~clk;

    // regulator settings as last written
    logic signed [VW-1:0] gain_prop = '0;
    logic signed [VW-1:0] gain_der = '0;
    logic signed [VW-1:0] gain_int = '0;
    logic signed [VW-1:0] out_floor = VMIN;
    logic signed [VW-1:0] out_ceil = VMAX;
    logic signed [VW-1:0] set_point = '0;
    logic [31:0] start_stamp = '0;

    // running regulator state
    logic [31:0] last_stamp = '0;
    logic signed [VW-1:0] last_err = '0;
    logic signed [IW-1:0] integral = '0;
    logic is_primed = 1'b0;

    sample_t pending_samples_q[$];
    drive_result_t drive_results_q[$];
    int samples_offered = 0;
    int samples_taken = 0;
    int mismatches = 0;
    int gap_left = 0;
    int burst_left = 0;
    int stall_left = 0;
    int calm_left = 0;
    int cycle_count = 0;
    logic [31:0] gen_stamp = '0;

    task automatic predict_drive(input logic signed [VW-1:0] meas, input logic [31:0] stamp);
        logic [31:0] dt;
        logic signed [VW+1:0] raw_err;
        logic signed [VW-1:0] err;
        logic signed [63:0] delta;
        logic signed [63:0] span;
        logic signed [63:0] rate;
        logic signed [127:0] sum;
        logic signed [127:0] part;
        logic signed [VW-1:0] drv;
        logic sat;
        drive_result_t res;
        if (stamp <= last_stamp)
            return;
        dt = stamp - last_stamp;
        raw_err = set_point - meas;
        if (raw_err > VMAX)
            err = VMAX;
        else if (raw_err < VMIN)
            err = VMIN;
        else
            err = raw_err[VW-1:0];
        if (!is_primed)
        begin
            last_err = err;
            last_stamp = stamp;
            is_primed = 1'b1;
            return;
        end
        delta = err - last_err;
        span = $signed({32'd0, dt});
        rate = delta / span;
        sum = gain_prop * err;
        sum = sum >>> FRAC;
        part = gain_der * rate;
        sum = sum + (part >>> FRAC);
        part = gain_int * integral;
        sum = sum + (part >>> FRAC);
        // ceiling first, then floor, so an inverted pair ends on the floor
        if (sum > out_ceil)
            sum = out_ceil;
        if (sum < out_floor)
            sum = out_floor;
        drv = sum[VW-1:0];
        sat = (drv >= out_ceil) || (drv <= out_floor);
        if (!sat)
        begin
            part = integral;
            part = part + err * $signed({1'b0, dt});
            if (part > IMAX)
                integral = IMAX;
            else if (part < IMIN)
                integral = IMIN;
            else
                integral = part[IW-1:0];
        end
        last_err = err;
        last_stamp = stamp;
        res.drive = drv;
        res.saturated = sat;
        drive_results_q.push_back(res);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VW-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            pidci_pkg::CFG_GAIN_P: gain_prop = data;
            pidci_pkg::CFG_GAIN_D: gain_der = data;
            pidci_pkg::CFG_GAIN_I: gain_int = data;
            pidci_pkg::CFG_OUTPUT_FLOOR: out_floor = data;
            pidci_pkg::CFG_OUTPUT_CEILING: out_ceil = data;
            pidci_pkg::CFG_SETPOINT: set_point = data;
            pidci_pkg::CFG_START_TIME:
            begin
                start_stamp = data;
                if (!is_primed)
                    last_stamp = data;
            end
            default: ;
        endcase
    endtask

    function automatic int signed_spread(input int unsigned span);
        return int'($urandom_range(0, 2 * span)) - int'(span);
    endfunction

    task automatic load_setting(input int mode);
        logic [VW-1:0] vals [0:6];
        vals[pidci_pkg::CFG_GAIN_P] = signed_spread(4 << 16);
        vals[pidci_pkg::CFG_GAIN_D] = signed_spread(4 << 16);
        vals[pidci_pkg::CFG_GAIN_I] = signed_spread(4 << 16);
        vals[pidci_pkg::CFG_OUTPUT_FLOOR] = -int'($urandom_range(1 << 16, 1 << 26));
        vals[pidci_pkg::CFG_OUTPUT_CEILING] = int'($urandom_range(1 << 16, 1 << 26));
        vals[pidci_pkg::CFG_SETPOINT] = signed_spread(1 << 20);
        vals[pidci_pkg::CFG_START_TIME] = $urandom;
        case (mode)
            0:
            begin
                vals[pidci_pkg::CFG_GAIN_P] = 32'h0001_0000;
                vals[pidci_pkg::CFG_GAIN_D] = 32'h0000_8000;
                vals[pidci_pkg::CFG_GAIN_I] = 32'h0000_4000;
                vals[pidci_pkg::CFG_OUTPUT_FLOOR] = -(100 << 16);
                vals[pidci_pkg::CFG_OUTPUT_CEILING] = 100 << 16;
                vals[pidci_pkg::CFG_SETPOINT] = '0;
                vals[pidci_pkg::CFG_START_TIME] = 32'd1000;
            end
            2:
            begin
                vals[pidci_pkg::CFG_GAIN_P] = VMAX;
                vals[pidci_pkg::CFG_GAIN_D] = VMIN;
                vals[pidci_pkg::CFG_GAIN_I] = VMAX;
                vals[pidci_pkg::CFG_OUTPUT_FLOOR] = VMIN;
                vals[pidci_pkg::CFG_OUTPUT_CEILING] = VMAX;
                vals[pidci_pkg::CFG_SETPOINT] = VMIN;
                vals[pidci_pkg::CFG_START_TIME] = 32'hFFFF_FFFF;
            end
            3:
            begin
                // floor above ceiling
                vals[pidci_pkg::CFG_OUTPUT_FLOOR] = int'($urandom_range(1 << 16, 1 << 22));
                vals[pidci_pkg::CFG_OUTPUT_CEILING] = -int'($urandom_range(0, 1 << 22));
            end
            4:
            begin
                vals[pidci_pkg::CFG_OUTPUT_FLOOR] = signed_spread(1 << 20);
                vals[pidci_pkg::CFG_OUTPUT_CEILING] = vals[pidci_pkg::CFG_OUTPUT_FLOOR];
                vals[pidci_pkg::CFG_START_TIME] = '0;
            end
            5:
            begin
                vals[pidci_pkg::CFG_GAIN_P] = VMIN;
                vals[pidci_pkg::CFG_GAIN_D] = VMAX;
                vals[pidci_pkg::CFG_GAIN_I] = VMIN;
                vals[pidci_pkg::CFG_OUTPUT_FLOOR] = -(1 << 24);
                vals[pidci_pkg::CFG_OUTPUT_CEILING] = 1 << 24;
            end
            6:
            begin
                // zero gains never saturate, so the integral runs to its limit
                vals[pidci_pkg::CFG_GAIN_P] = '0;
                vals[pidci_pkg::CFG_GAIN_D] = '0;
                vals[pidci_pkg::CFG_GAIN_I] = '0;
                vals[pidci_pkg::CFG_OUTPUT_FLOOR] = VMIN;
                vals[pidci_pkg::CFG_OUTPUT_CEILING] = VMAX;
                vals[pidci_pkg::CFG_SETPOINT] = VMAX;
            end
            7:
            begin
                vals[pidci_pkg::CFG_GAIN_P] = $urandom;
                vals[pidci_pkg::CFG_GAIN_D] = $urandom;
                vals[pidci_pkg::CFG_GAIN_I] = $urandom;
                vals[pidci_pkg::CFG_OUTPUT_FLOOR] = $urandom;
                vals[pidci_pkg::CFG_OUTPUT_CEILING] = $urandom;
                vals[pidci_pkg::CFG_SETPOINT] = $urandom;
            end
            default: ;
        endcase
        for (int i = pidci_pkg::CFG_GAIN_P; i <= pidci_pkg::CFG_START_TIME; i++)
            write_reg(i[IDX_W-1:0], vals[i]);
        if (mode == 2)
            write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic push_sample(input logic signed [VW-1:0] meas, input logic [31:0] stamp);
        sample_t s;
        s.measurement = meas;
        s.timestamp = stamp;
        pending_samples_q.push_back(s);
        if (stamp > gen_stamp)
            gen_stamp = stamp;
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        int unsigned pick;
        logic [31:0] step;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            s.measurement = set_point + signed_spread(1 << 18);
        else if (pick < 90)
            s.measurement = set_point + signed_spread(1 << 26);
        else
            s.measurement = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            s.timestamp = gen_stamp;
        else if (pick < 6)
            s.timestamp = $urandom_range(0, gen_stamp);
        else
        begin
            if (pick < 70)
                step = $urandom_range(1, 16);
            else if (pick < 90)
                step = $urandom_range(17, 1 << 16);
            else if (pick < 99)
                step = $urandom_range(1 << 16, 1 << 22);
            else
                step = $urandom_range(1 << 22, 1 << 26);
            // stay clear of the top so the tail can still make progress
            if (gen_stamp > STAMP_CAP - step)
                s.timestamp = gen_stamp;
            else
                s.timestamp = gen_stamp + step;
            gen_stamp = s.timestamp;
        end
        return s;
    endfunction

    task automatic wait_idle();
        while (pending_samples_q.size() != 0 || samples_taken != samples_offered ||
               drive_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sample sender: bursts of transfers with random gaps
    always @(negedge clk)
    begin : drive_samples
        sample_t staged;
        if (!rst_n)
            in_if.valid <= 1'b0;
        else if (!(in_if.valid && samples_taken != samples_offered))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_if.valid <= 1'b0;
            end
            else if (pending_samples_q.size() > 0)
            begin
                staged = pending_samples_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.measurement <= staged.measurement;
                in_if.timestamp <= staged.timestamp;
                samples_offered++;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
                end
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // result receiver: calm stretches, otherwise random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else if (calm_left > 0)
        begin
            calm_left--;
            out_if.ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_if.ready <= 1'b0;
        end
        else
        begin
            out_if.ready <= 1'b1;
            case ($urandom_range(0, 31))
                0: calm_left = $urandom_range(200, 2000);
                1, 2, 3: stall_left = $urandom_range(1, 100);
                default: ;
            endcase
        end
    end

    always @(posedge clk)
    begin : watch_ports
        drive_result_t want;
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
            begin
                predict_drive(in_if.measurement, in_if.timestamp);
                samples_taken++;
            end
            if (out_if.valid && out_if.ready)
            begin
                if (drive_results_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected transfer, expected none, actual drive %0d sat %0b",
                             $time, out_if.drive, out_if.saturated);
                end
                else
                begin
                    want = drive_results_q.pop_front();
                    if (want.drive !== out_if.drive)
                    begin
                        mismatches++;
                        $display("%0t: drive expected %0d actual %0d",
                                 $time, want.drive, out_if.drive);
                    end
                    if (want.saturated !== out_if.saturated)
                    begin
                        mismatches++;
                        $display("%0t: saturated expected %0b actual %0b",
                                 $time, want.saturated, out_if.saturated);
                    end
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pid_with_conditional_integration: mismatch");
        $finish;
    end

    initial
    begin
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.measurement = '0;
        in_if.timestamp = '0;
        out_if.ready = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // start time loaded before the first sample takes effect
        load_setting(0);
        push_sample(32'sd0, 32'd5);
        push_sample(32'sd0, 32'd1000);
        push_sample(VMAX, 32'd1001);
        push_sample(VMIN, 32'd1002);
        push_sample(32'sd0, 32'd1002);
        push_sample(32'sd0, 32'd1003);
        push_sample(32'sd3, 32'd1005);
        push_sample(32'sd0, 32'd1006);
        push_sample(32'sh0001_0000, 32'd1010);
        push_sample(-32'sh0001_0000, 32'd1011);
        push_sample(32'sd12345, 32'd500);
        push_sample(32'sh0000_1234, 32'd1011 + 32'h00FF_FFFF);
        push_sample(32'sh7FFF_0000, 32'h0100_1000);
        push_sample(-32'sh7FFF_0000, 32'h0100_1001);
        push_sample(32'sh5555_AAAA, 32'h0100_1002);
        push_sample(-32'sh2AAA_5555, 32'h0200_0000);
        wait_idle();

        for (int mode = 1; mode <= 7; mode++)
        begin
            load_setting(mode);
            repeat (PHASE_ITEMS) pending_samples_q.push_back(random_sample());
            wait_idle();
        end

        // top of the tick range; once all ones is taken every sample is stale
        push_sample(32'sh0002_0000, 32'hFFFF_FFFE);
        push_sample(-32'sh0002_0000, 32'hFFFF_FFFF);
        push_sample(32'sd0, 32'hFFFF_FFFF);
        push_sample(32'sd0, 32'd0);
        push_sample(32'sh1234_5678, 32'h8000_0000);
        wait_idle();

        if (mismatches == 0)
            $display("pid_with_conditional_integration: match");
        else
            $display("pid_with_conditional_integration: mismatch");
        $finish;
    end

endmodule
